// ----- rtl/core/utp_pkg.sv -----
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types, constants and helpers of the utilization trend predictor.
// ----------------------------------------------------------------------------
package utp_pkg;

    localparam int UTP_MAX_PATTERNS = 16;
    localparam int UTP_SIG_W        = 64;
    localparam int UTP_LVL_W        = 7;
    localparam int UTP_PRED_W       = 11;
    localparam int UTP_CFG_W        = 5;
    localparam int UTP_HAM_LIMIT    = 8;
    localparam int UTP_LVL_MAX      = 100;

    // Request operation codes.
    localparam logic UTP_OP_SAMPLE = 1'b0;
    localparam logic UTP_OP_WRITE  = 1'b1;

    typedef logic [UTP_LVL_W-1:0]         t_level;
    typedef logic signed [UTP_PRED_W-1:0] t_pred;

    localparam t_level UTP_DEFAULT_PRED = t_level'(50);

    // One pattern table entry as stored in the RAM.
    typedef struct packed {
        logic [UTP_SIG_W-1:0] sig_hi;
        logic [UTP_SIG_W-1:0] sig_lo;
        t_level               weight;
        t_level               target;
    } t_entry;

    localparam int UTP_ENTRY_W = $bits(t_entry);

    // Compare stage result of the pattern search.
    typedef struct packed {
        logic   valid;
        logic   hit;
        logic   last;
        t_level weight;
        t_level target;
    } t_match_st;

    // Clamp a signed prediction to 0..100.
    function automatic t_level clamp_level(input t_pred p);
        t_level r;
        if (p[UTP_PRED_W-1]) begin
            r = '0;
        end else if (p[UTP_PRED_W-2:0] > (UTP_PRED_W-1)'(UTP_LVL_MAX)) begin
            r = t_level'(UTP_LVL_MAX);
        end else begin
            r = p[UTP_LVL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/utp_ram.sv -----
// ----------------------------------------------------------------------------
// utp_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module utp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/utp_trend.sv -----
// ----------------------------------------------------------------------------
// utp_trend
// Sample history, two-stage trend prediction and signature build.
// ----------------------------------------------------------------------------
module utp_trend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [6:0]                    i_util_percent,
    input  logic [15:0]                   i_irq_count,
    input  logic [6:0]                    i_iowait_percent,
    input  logic [15:0]                   i_runnable_tasks,
    output utp_pkg::t_pred                o_pred,
    output logic [utp_pkg::UTP_SIG_W-1:0] o_sig_lo,
    output logic [utp_pkg::UTP_SIG_W-1:0] o_sig_hi,
    output logic                          o_full
);

    localparam logic [7:0] SIG_BIAS  = 8'd100;
    localparam logic [2:0] FULL_CNT  = 3'd5;

    logic [6:0]  r_u   [4];
    logic [15:0] r_irq [3];
    logic [6:0]  r_iow [3];
    logic [7:0]  r_tb;
    logic [2:0]  r_cnt;

    // stage 1
    logic signed [7:0] t1, t2, t3;
    logic signed [9:0] n3;
    logic [8:0]        a3;
    logic signed [8:0] a4;
    logic [7:0]        abs4, q4u;
    logic signed [16:0] di1, di2;
    logic [15:0]       ad1, ad2;
    logic [7:0]        dw1, dw2;

    logic [16:0] r_p3;
    logic        r_n3neg;
    logic [7:0]  r_q4;
    logic [31:0] r_pd1, r_pd2;
    logic        r_d1neg, r_d2neg;
    logic [7:0]  r_b0, r_b1, r_b4, r_b5;

    // stage 2
    logic [7:0]  q3, q10a, q10b, b2, b3;
    logic [10:0] sq3, pred_w;

    utp_pkg::t_pred              r_pred;
    logic [utp_pkg::UTP_SIG_W-1:0] r_slo, r_shi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_u[k] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_irq[k] <= '0;
                r_iow[k] <= '0;
            end
            r_tb  <= '0;
            r_cnt <= '0;
        end else if (i_load) begin
            r_u[3]   <= r_u[2];
            r_u[2]   <= r_u[1];
            r_u[1]   <= r_u[0];
            r_u[0]   <= i_util_percent;
            r_irq[2] <= r_irq[1];
            r_irq[1] <= r_irq[0];
            r_irq[0] <= i_irq_count;
            r_iow[2] <= r_iow[1];
            r_iow[1] <= r_iow[0];
            r_iow[0] <= i_iowait_percent;
            r_tb     <= i_runnable_tasks[7:0];
            if (r_cnt < FULL_CNT) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_comb begin
        t1   = $signed({1'b0, r_u[0]}) - $signed({1'b0, r_u[1]});
        t2   = $signed({1'b0, r_u[1]}) - $signed({1'b0, r_u[2]});
        t3   = $signed({1'b0, r_u[2]}) - $signed({1'b0, r_u[3]});
        n3   = (10'(t1) <<< 1) + 10'(t2);
        a3   = n3[9] ? 9'(-n3) : n3[8:0];
        a4   = 9'(t1) - 9'(t3);
        abs4 = a4[8] ? 8'(-a4) : a4[7:0];
        q4u  = abs4 >> 2;
        di1  = $signed({1'b0, r_irq[0]}) - $signed({1'b0, r_irq[1]});
        di2  = $signed({1'b0, r_irq[1]}) - $signed({1'b0, r_irq[2]});
        ad1  = di1[16] ? 16'(-di1) : di1[15:0];
        ad2  = di2[16] ? 16'(-di2) : di2[15:0];
        dw1  = 8'({1'b0, r_iow[0]}) - 8'({1'b0, r_iow[1]});
        dw2  = 8'({1'b0, r_iow[1]}) - 8'({1'b0, r_iow[2]});
    end

    // Divide by 3 and by 10 through reciprocal multiplies on magnitudes.
    always_ff @(posedge i_clk) begin
        r_p3    <= 17'(a3) * 17'd171;
        r_n3neg <= n3[9];
        r_q4    <= a4[8] ? (8'd0 - q4u) : q4u;
        r_pd1   <= 32'(ad1) * 32'd52429;
        r_pd2   <= 32'(ad2) * 32'd52429;
        r_d1neg <= di1[16];
        r_d2neg <= di2[16];
        r_b0    <= 8'(t1) + SIG_BIAS;
        r_b1    <= 8'(t2) + SIG_BIAS;
        r_b4    <= dw1 + SIG_BIAS;
        r_b5    <= dw2 + SIG_BIAS;
    end

    always_comb begin
        q3     = 8'(r_p3 >> 9);
        sq3    = r_n3neg ? (11'd0 - 11'(q3)) : 11'(q3);
        pred_w = 11'(r_u[0]) + sq3 + {{3{r_q4[7]}}, r_q4};
        q10a   = r_pd1[26:19];
        q10b   = r_pd2[26:19];
        b2     = (r_d1neg ? (8'd0 - q10a) : q10a) + SIG_BIAS;
        b3     = (r_d2neg ? (8'd0 - q10b) : q10b) + SIG_BIAS;
    end

    always_ff @(posedge i_clk) begin
        r_pred <= utp_pkg::t_pred'(pred_w);
        r_slo  <= {{1'b0, r_iow[0]}, {1'b0, r_u[0]}, r_b5, r_b4, b3, b2, r_b1, r_b0};
        r_shi  <= {56'd0, r_tb};
    end

    assign o_pred   = r_pred;
    assign o_sig_lo = r_slo;
    assign o_sig_hi = r_shi;
    assign o_full   = (r_cnt == FULL_CNT);

endmodule

// ----- rtl/core/utp_match.sv -----
// ----------------------------------------------------------------------------
// utp_match
// Hamming distance check of one pattern entry per cycle, with the group counts registered.
// ----------------------------------------------------------------------------
module utp_match (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_flush,
    input  logic                            i_valid,
    input  logic                            i_last,
    input  logic [utp_pkg::UTP_ENTRY_W-1:0] i_rd_data,
    input  logic [utp_pkg::UTP_SIG_W-1:0]   i_sig_lo,
    input  logic [utp_pkg::UTP_SIG_W-1:0]   i_sig_hi,
    output utp_pkg::t_match_st              o_st
);

    function automatic logic [3:0] popcnt8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(b[k]);
        end
        return n;
    endfunction

    utp_pkg::t_entry entry;
    logic [127:0]    diff;
    logic [5:0]      grp [4];

    logic [5:0]      r_grp [4];
    logic            r_valid;
    logic            r_last;
    utp_pkg::t_level r_weight, r_target;
    logic [7:0]      total;

    always_comb begin
        entry = utp_pkg::t_entry'(i_rd_data);
        diff  = {entry.sig_hi ^ i_sig_hi, entry.sig_lo ^ i_sig_lo};
        for (int g = 0; g < 4; g++) begin
            grp[g] = '0;
            for (int j = 0; j < 4; j++) begin
                grp[g] = grp[g] + 6'(popcnt8(diff[(4*g+j)*8 +: 8]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid & ~i_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 4; g++) r_grp[g] <= grp[g];
        r_last   <= i_last;
        r_weight <= entry.weight;
        r_target <= entry.target;
    end

    assign total = 8'(r_grp[0]) + 8'(r_grp[1]) + 8'(r_grp[2]) + 8'(r_grp[3]);

    assign o_st.valid  = r_valid;
    assign o_st.hit    = (total < 8'(utp_pkg::UTP_HAM_LIMIT));
    assign o_st.last   = r_last;
    assign o_st.weight = r_weight;
    assign o_st.target = r_target;

endmodule

// ----- rtl/core/utilization_trend_predictor_top.sv -----
// ----------------------------------------------------------------------------
// utilization_trend_predictor_top
// Trend based utilization predictor with a pattern table nudge.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_ready    i_op .. i_target_level
//   result    out        o_valid / i_ready    o_predicted_util, o_pattern_hit
//   config    in         i_cfg_we             i_cfg_data (patterns_in_use)
//
// A write request returns nothing. A sample request steps S_T1, S_T2, S_DEC;
// with a short history or no slots in use it goes on to S_EMIT, else it reads
// the slots in order (one read a cycle, match result behind r_v1 and the match
// register) up to the first hit or the last slot in use, then on a hit runs
// S_MUL1, S_MUL2 and S_ADJ to multiply and adjust. Reset clears history and
// control; the pattern table holds no reset and no clearing pass runs. A stalled
// result sits in the output register while the next request is already taken.
// ----------------------------------------------------------------------------
module utilization_trend_predictor_top #(
    parameter int MAX_PATTERNS = utp_pkg::UTP_MAX_PATTERNS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [6:0]  i_util_percent,
    input  logic [15:0] i_irq_count,
    input  logic [6:0]  i_iowait_percent,
    input  logic [15:0] i_runnable_tasks,
    input  logic [3:0]  i_pattern_slot,
    input  logic [63:0] i_signature_low,
    input  logic [63:0] i_signature_high,
    input  logic [6:0]  i_weight_percent,
    input  logic [6:0]  i_target_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_predicted_util,
    output logic        o_pattern_hit,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    localparam int AW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CW   = $clog2(MAX_PATTERNS + 1);
    localparam int CMPW = (CW > utp_pkg::UTP_CFG_W) ? CW : utp_pkg::UTP_CFG_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_T1   = 4'd1;
    localparam logic [3:0] S_T2   = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_SRCH = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_ADJ  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cfg;

    logic req_acc, sample_acc, wr_acc;
    logic [CMPW-1:0] slot_ext, cfg_ext, limit_w;
    logic [CW-1:0]   limit;

    utp_pkg::t_entry wr_entry;
    logic [utp_pkg::UTP_ENTRY_W-1:0] rd_data;

    utp_pkg::t_pred              pred;
    logic [utp_pkg::UTP_SIG_W-1:0] sig_lo, sig_hi;
    logic                        full;

    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_v1, n_v1;
    logic          r_last1, n_last1;
    logic          issue, leave;
    utp_pkg::t_match_st st;

    utp_pkg::t_level r_w, n_w, r_t, n_t;
    logic signed [17:0] r_prod, n_prod;
    logic signed [17:0] adj18, w18;
    logic [16:0]        aprod;
    logic [29:0]        r_qp, n_qp;
    logic               r_neg, n_neg;
    logic [9:0]         qadj;
    logic [10:0]        delta;
    utp_pkg::t_pred     newp;

    utp_pkg::t_level r_res_pred, n_res_pred;
    logic            r_res_hit, n_res_hit;
    logic            r_ovalid, n_ovalid;
    utp_pkg::t_level r_opred, n_opred;
    logic            r_ohit, n_ohit;

    assign o_ready    = (r_state == S_IDLE);
    assign req_acc    = i_valid & o_ready;
    assign sample_acc = req_acc & (i_op == utp_pkg::UTP_OP_SAMPLE);
    assign slot_ext   = CMPW'(i_pattern_slot);
    assign wr_acc     = req_acc & (i_op == utp_pkg::UTP_OP_WRITE) &
                        (slot_ext < CMPW'(MAX_PATTERNS));

    assign cfg_ext = CMPW'(r_cfg);
    assign limit_w = (cfg_ext > CMPW'(MAX_PATTERNS)) ? CMPW'(MAX_PATTERNS) : cfg_ext;
    assign limit   = limit_w[CW-1:0];

    assign wr_entry.sig_hi = i_signature_high;
    assign wr_entry.sig_lo = i_signature_low;
    assign wr_entry.weight = i_weight_percent;
    assign wr_entry.target = i_target_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    utp_ram #(
        .WIDTH (utp_pkg::UTP_ENTRY_W),
        .DEPTH (MAX_PATTERNS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_acc),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    utp_trend u_trend (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (sample_acc),
        .i_util_percent   (i_util_percent),
        .i_irq_count      (i_irq_count),
        .i_iowait_percent (i_iowait_percent),
        .i_runnable_tasks (i_runnable_tasks),
        .o_pred           (pred),
        .o_sig_lo         (sig_lo),
        .o_sig_hi         (sig_hi),
        .o_full           (full)
    );

    utp_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (leave),
        .i_valid   (r_v1),
        .i_last    (r_last1),
        .i_rd_data (rd_data),
        .i_sig_lo  (sig_lo),
        .i_sig_hi  (sig_hi),
        .o_st      (st)
    );

    // Stop the search at the first hit or after the last slot.
    assign leave = (r_state == S_SRCH) & st.valid & (st.hit | st.last);
    assign issue = (r_state == S_SRCH) & (r_rd_idx < limit) & ~leave;

    always_comb begin
        adj18 = 18'($signed({4'd0, r_t})) - 18'(pred);
        w18   = $signed({11'd0, r_w});
        aprod = r_prod[17] ? 17'(-r_prod) : r_prod[16:0];
        qadj  = r_qp[28:19];
        delta = r_neg ? (11'd0 - 11'(qadj)) : 11'(qadj);
        newp  = utp_pkg::t_pred'(11'(pred) + delta);
    end

    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        n_v1       = 1'b0;
        n_last1    = r_last1;
        n_w        = r_w;
        n_t        = r_t;
        n_prod     = r_prod;
        n_qp       = r_qp;
        n_neg      = r_neg;
        n_res_pred = r_res_pred;
        n_res_hit  = r_res_hit;
        n_ovalid   = r_ovalid & ~i_ready;
        n_opred    = r_opred;
        n_ohit     = r_ohit;

        case (r_state)
            S_IDLE: begin
                if (sample_acc) begin
                    n_state = S_T1;
                end
            end
            S_T1: n_state = S_T2;
            S_T2: n_state = S_DEC;
            S_DEC: begin
                n_rd_idx = '0;
                if (!full) begin
                    n_res_pred = utp_pkg::UTP_DEFAULT_PRED;
                    n_res_hit  = 1'b0;
                    n_state    = S_EMIT;
                end else if (limit == '0) begin
                    n_res_pred = utp_pkg::clamp_level(pred);
                    n_res_hit  = 1'b0;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_v1     = 1'b1;
                    n_last1  = (r_rd_idx == limit - CW'(1));
                end
                if (leave) begin
                    if (st.hit) begin
                        n_w     = st.weight;
                        n_t     = st.target;
                        n_state = S_MUL1;
                    end else begin
                        n_res_pred = utp_pkg::clamp_level(pred);
                        n_res_hit  = 1'b0;
                        n_state    = S_EMIT;
                    end
                end
            end
            S_MUL1: begin
                n_prod  = adj18 * w18;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                // divide by 100 as a reciprocal multiply on the magnitude
                n_neg   = r_prod[17];
                n_qp    = 30'(aprod) * 30'd5243;
                n_state = S_ADJ;
            end
            S_ADJ: begin
                n_res_pred = utp_pkg::clamp_level(newp);
                n_res_hit  = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_opred  = r_res_pred;
                    n_ohit   = r_res_hit;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v1     <= 1'b0;
            r_ovalid <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_v1     <= n_v1;
            r_ovalid <= n_ovalid;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last1    <= n_last1;
        r_w        <= n_w;
        r_t        <= n_t;
        r_prod     <= n_prod;
        r_qp       <= n_qp;
        r_neg      <= n_neg;
        r_res_pred <= n_res_pred;
        r_res_hit  <= n_res_hit;
        r_opred    <= n_opred;
        r_ohit     <= n_ohit;
    end

    assign o_valid          = r_ovalid;
    assign o_predicted_util = r_opred;
    assign o_pattern_hit    = r_ohit;

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_acc |=> (r_state == S_T1))
        else $error("sample request did not start the trend stages");

    a_match_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st.valid |-> (r_state == S_SRCH))
        else $error("match result outside the search");

    a_hit_needs_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pattern_hit) |-> full)
        else $error("pattern hit with short history");

    a_short_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !full) |-> (o_predicted_util == utp_pkg::UTP_DEFAULT_PRED))
        else $error("short history must predict the default level");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_predicted_util <= 7'(utp_pkg::UTP_LVL_MAX)))
        else $error("prediction out of range");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: utilization trend predictor testbench
// Drives samples and pattern-table writes through the request channel, with
// random gaps and result back-pressure, and checks every result against a
// cycle-free forecast of prediction and pattern match. A directed table
// covers short history and field extremes. Random phases follow under
// several slot counts, and most of them plant a pattern next to the
// signature of the sample that comes right after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import utp_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 185;
    localparam int HOLD_PHASE    = 2;
    localparam int MAX_PRINTS    = 50;

    typedef enum bit {OP_SAMPLE = 1'b0, OP_WRITE = 1'b1} op_e;

    typedef struct {
        op_e        op;
        bit [6:0]   util;
        bit [15:0]  irq;
        bit [6:0]   iowait;
        bit [15:0]  tasks;
        bit [3:0]   slot;
        bit [63:0]  sig_lo;
        bit [63:0]  sig_hi;
        bit [6:0]   weight;
        bit [6:0]   target;
    } request_t;

    typedef struct {
        bit [6:0] util;
        bit       hit;
        int       tag;
    } forecast_t;

    typedef struct {
        request_t req;
        bit       typed;
        bit [6:0] want_util;
    } vector_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [6:0]  i_util_percent;
    logic [15:0] i_irq_count;
    logic [6:0]  i_iowait_percent;
    logic [15:0] i_runnable_tasks;
    logic [3:0]  i_pattern_slot;
    logic [63:0] i_signature_low;
    logic [63:0] i_signature_high;
    logic [6:0]  i_weight_percent;
    logic [6:0]  i_target_level;
    logic        o_valid;
    logic        i_ready;
    logic [6:0]  o_predicted_util;
    logic        o_pattern_hit;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_data;

    // forecast state
    int        hist_util[4];
    int        hist_irq[3];
    int        hist_iow[3];
    int        samples_seen;
    int        slots_in_use;
    bit [63:0] slot_sig_lo[UTP_MAX_PATTERNS];
    bit [63:0] slot_sig_hi[UTP_MAX_PATTERNS];
    int        slot_weight[UTP_MAX_PATTERNS];
    int        slot_target[UTP_MAX_PATTERNS];

    forecast_t pending[$];

    int mismatches;
    int requests_sent;
    int samples_sent;
    int writes_sent;
    int results_seen;
    int hits_expected;
    int settings_loaded;
    bit calm;
    bit hold_wanted;
    bit hold_over;

    utilization_trend_predictor_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_util_percent   (i_util_percent),
        .i_irq_count      (i_irq_count),
        .i_iowait_percent (i_iowait_percent),
        .i_runnable_tasks (i_runnable_tasks),
        .i_pattern_slot   (i_pattern_slot),
        .i_signature_low  (i_signature_low),
        .i_signature_high (i_signature_high),
        .i_weight_percent (i_weight_percent),
        .i_target_level   (i_target_level),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_predicted_util (o_predicted_util),
        .o_pattern_hit    (o_pattern_hit),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    // Mostly short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [6:0] pick_level();
        if ($urandom_range(0, 6) == 0) return 7'($urandom_range(101, 127));
        return 7'($urandom_range(0, 100));
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.op     = op_e'($urandom_range(0, 1));
        r.util   = 7'($urandom);
        r.irq    = 16'($urandom);
        r.iowait = 7'($urandom);
        r.tasks  = 16'($urandom);
        r.slot   = 4'($urandom);
        r.sig_lo = {$urandom, $urandom};
        r.sig_hi = {$urandom, $urandom};
        r.weight = pick_level();
        r.target = pick_level();
        return r;
    endfunction

    // Follow the current trend most of the time, jump now and then.
    function automatic request_t next_sample();
        request_t r;
        int       u;
        int       w;
        r = random_request();
        r.op = OP_SAMPLE;
        if ($urandom_range(0, 4) != 0) begin
            u = hist_util[0] + int'($urandom_range(0, 24)) - 12;
            w = hist_iow[0] + int'($urandom_range(0, 12)) - 6;
            r.util   = 7'((u < 0) ? 0 : (u > 100) ? 100 : u);
            r.iowait = 7'((w < 0) ? 0 : (w > 100) ? 100 : w);
            r.irq    = 16'(hist_irq[0] + int'($urandom_range(0, 4000)) - 2000);
        end else begin
            r.util   = pick_level();
            r.iowait = pick_level();
        end
        return r;
    endfunction

    // Signature that sample r would produce against the current history.
    function automatic void trend_signature(input request_t r, output bit [63:0] lo,
                                            output bit [63:0] hi);
        int t1, t2, di1, di2, dw1, dw2;
        t1  = int'(r.util) - hist_util[0];
        t2  = hist_util[0] - hist_util[1];
        di1 = int'(r.irq) - hist_irq[0];
        di2 = hist_irq[0] - hist_irq[1];
        dw1 = int'(r.iowait) - hist_iow[0];
        dw2 = hist_iow[0] - hist_iow[1];
        lo = {8'(r.iowait), 8'(r.util), 8'(dw2 + 100), 8'(dw1 + 100),
              8'(di2 / 10 + 100), 8'(di1 / 10 + 100), 8'(t2 + 100), 8'(t1 + 100)};
        hi = {56'd0, r.tasks[7:0]};
    endfunction

    // Advance the forecast state by one request; return 1 if it yields a result.
    function automatic bit forecast_request(input request_t r, output forecast_t f);
        bit [63:0] lo, hi;
        int        t1, t2, t3, est, lim;
        f.util = 7'd50;
        f.hit  = 1'b0;
        f.tag  = requests_sent;
        if (r.op == OP_WRITE) begin
            slot_sig_lo[r.slot] = r.sig_lo;
            slot_sig_hi[r.slot] = r.sig_hi;
            slot_weight[r.slot] = int'(r.weight);
            slot_target[r.slot] = int'(r.target);
            return 1'b0;
        end
        trend_signature(r, lo, hi);
        hist_util[3] = hist_util[2];
        hist_util[2] = hist_util[1];
        hist_util[1] = hist_util[0];
        hist_util[0] = int'(r.util);
        hist_irq[2]  = hist_irq[1];
        hist_irq[1]  = hist_irq[0];
        hist_irq[0]  = int'(r.irq);
        hist_iow[2]  = hist_iow[1];
        hist_iow[1]  = hist_iow[0];
        hist_iow[0]  = int'(r.iowait);
        if (samples_seen < 5) samples_seen++;
        if (samples_seen >= 5) begin
            t1  = hist_util[0] - hist_util[1];
            t2  = hist_util[1] - hist_util[2];
            t3  = hist_util[2] - hist_util[3];
            est = hist_util[0] + (t1 * 2 + t2) / 3 + ((t1 - t2) + (t2 - t3)) / 4;
            lim = (slots_in_use > UTP_MAX_PATTERNS) ? UTP_MAX_PATTERNS : slots_in_use;
            // first slot within reach wins
            for (int i = 0; i < lim; i++) begin
                if (!f.hit && $countones(slot_sig_lo[i] ^ lo) +
                        $countones(slot_sig_hi[i] ^ hi) < UTP_HAM_LIMIT) begin
                    est = est + ((slot_target[i] - est) * slot_weight[i]) / 100;
                    f.hit = 1'b1;
                end
            end
            if (est < 0) est = 0;
            if (est > 100) est = 100;
            f.util = 7'(est);
        end
        return 1'b1;
    endfunction

    task automatic send_request(input request_t r, input bit typed, input bit [6:0] typed_util);
        int        gap;
        forecast_t f;
        gap = (calm || (hold_wanted && !hold_over)) ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_op             <= r.op;
        i_util_percent   <= r.util;
        i_irq_count      <= r.irq;
        i_iowait_percent <= r.iowait;
        i_runnable_tasks <= r.tasks;
        i_pattern_slot   <= r.slot;
        i_signature_low  <= r.sig_lo;
        i_signature_high <= r.sig_hi;
        i_weight_percent <= r.weight;
        i_target_level   <= r.target;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (forecast_request(r, f)) begin
            if (typed) begin
                f.util = typed_util;
                f.hit  = 1'b0;
            end
            pending.push_back(f);
            samples_sent++;
            if (f.hit) hits_expected++;
        end else begin
            writes_sent++;
        end
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        // a trailing write may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_slot_count(input int value);
        wait_until_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 5'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        slots_in_use = value;
        settings_loaded++;
    endtask

    task automatic add_row(ref vector_t tbl[$], input op_e op, input int util, input int irq,
                           input int iow, input int tasks, input bit typed,
                           input int want);
        vector_t v;
        v.req        = random_request();
        v.req.op     = op;
        v.req.util   = 7'(util);
        v.req.irq    = 16'(irq);
        v.req.iowait = 7'(iow);
        v.req.tasks  = 16'(tasks);
        v.typed      = typed;
        v.want_util  = 7'(want);
        tbl.push_back(v);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int        stall_left;
        int        hold_left;
        bit        hold_started;
        forecast_t want;
        stall_left   = 0;
        hold_left    = 0;
        hold_started = 1'b0;
        i_ready      = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready === 1'b1) begin
                results_seen++;
                if (pending.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              results_seen));
                end else begin
                    want = pending.pop_front();
                    if (o_predicted_util !== want.util) begin
                        report_mismatch($sformatf("request %0d: predicted_util %0d, want %0d",
                                                  want.tag, o_predicted_util, want.util));
                    end
                    if (o_pattern_hit !== want.hit) begin
                        report_mismatch($sformatf("request %0d: pattern_hit %0b, want %0b",
                                                  want.tag, o_pattern_hit, want.hit));
                    end
                end
            end
            if (hold_wanted && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) hold_over = 1'b1;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_ready === 1'b1) ||
                (o_valid === 1'b1 && i_ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TIMEOUT: nothing moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        vector_t   directed[$];
        int        slot_counts[6];
        int        phase_start;
        int        lim_now;
        int        flips;
        int        bitpos;
        int        roll;
        request_t  s;
        request_t  w;
        bit [63:0] lo, hi;

        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_op             = 1'b0;
        i_util_percent   = '0;
        i_irq_count      = '0;
        i_iowait_percent = '0;
        i_runnable_tasks = '0;
        i_pattern_slot   = '0;
        i_signature_low  = '0;
        i_signature_high = '0;
        i_weight_percent = '0;
        i_target_level   = '0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        calm             = 1'b0;
        hold_wanted      = 1'b0;
        hold_over        = 1'b0;
        slot_counts      = '{16, 1, 31, 0, 7, 17};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_slot_count(0);

        // Short history answers 50 whatever the sample carries.
        //                 op         util irq    iow  tasks    typed want
        add_row(directed, OP_SAMPLE, 0,   0,     0,   'h0000,  1'b1, 50);
        add_row(directed, OP_SAMPLE, 100, 65535, 100, 'hFFFF,  1'b1, 50);
        add_row(directed, OP_SAMPLE, 127, 0,     127, 'h00FF,  1'b1, 50);
        add_row(directed, OP_SAMPLE, 0,   65535, 0,   'h0100,  1'b1, 50);
        add_row(directed, OP_SAMPLE, 0,   0,     0,   'h0000,  1'b0, 0);
        add_row(directed, OP_SAMPLE, 127, 65535, 127, 'hFF00,  1'b0, 0);
        add_row(directed, OP_SAMPLE, 0,   0,     0,   'h7FFF,  1'b0, 0);
        // Fill every slot so that no later search reads an unwritten one.
        for (int k = 0; k < UTP_MAX_PATTERNS; k++) begin
            add_row(directed, OP_WRITE, 0, 0, 0, 0, 1'b0, 0);
            directed[$].req.slot   = 4'(k);
            directed[$].req.sig_lo = (k == 0) ? '1 : (k == 1) ? '0 : directed[$].req.sig_lo;
            directed[$].req.sig_hi = (k == 0) ? '1 : (k == 1) ? '0 : directed[$].req.sig_hi;
            directed[$].req.weight = (k == 0) ? 7'd127 : (k == 1) ? 7'd0 :
                                     (k == 2) ? 7'd100 : directed[$].req.weight;
            directed[$].req.target = (k == 0) ? 7'd127 : (k == 1) ? 7'd0 :
                                     (k == 2) ? 7'd100 : directed[$].req.target;
        end
        add_row(directed, OP_SAMPLE, 64, 32768, 64, 'h8000, 1'b0, 0);

        foreach (directed[k]) begin
            send_request(directed[k].req, directed[k].typed, directed[k].want_util);
        end

        foreach (slot_counts[p]) begin
            load_slot_count(slot_counts[p]);
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 3) == 0);
                if (p == HOLD_PHASE && requests_sent - phase_start >= 60) hold_wanted = 1'b1;
                lim_now = (slots_in_use > UTP_MAX_PATTERNS) ? UTP_MAX_PATTERNS : slots_in_use;
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    // Plant a pattern a few bits away from the next sample's signature.
                    s = next_sample();
                    trend_signature(s, lo, hi);
                    flips = ($urandom_range(0, 2) == 0) ? $urandom_range(7, 8)
                                                        : $urandom_range(0, 12);
                    repeat (flips) begin
                        bitpos = $urandom_range(0, 127);
                        if (bitpos < 64) lo[bitpos] = ~lo[bitpos];
                        else hi[bitpos - 64] = ~hi[bitpos - 64];
                    end
                    w = random_request();
                    w.op     = OP_WRITE;
                    w.slot   = 4'((lim_now > 0) ? $urandom_range(0, lim_now - 1)
                                                : $urandom_range(0, 15));
                    w.sig_lo = lo;
                    w.sig_hi = hi;
                    send_request(w, 1'b0, 7'd0);
                    send_request(s, 1'b0, 7'd0);
                end else if (roll < 85) begin
                    send_request(next_sample(), 1'b0, 7'd0);
                end else begin
                    w = random_request();
                    w.op = OP_WRITE;
                    send_request(w, 1'b0, 7'd0);
                end
            end
            calm = 1'b0;
        end

        wait_until_drained();
        $display("Sent %0d requests (%0d samples, %0d slot writes) over %0d slot-count settings",
                 requests_sent, samples_sent, writes_sent, settings_loaded);
        $display("Checked %0d results, %0d expected pattern-adjusted, %0d mismatches",
                 results_seen, hits_expected, mismatches);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
